>>> hdl/gsd_pkg.sv
`default_nettype none

package gsd_pkg;

	localparam int RATE_W = 16;
	localparam int MAG_W  = 16;
	localparam int SQ_W   = 32;
	localparam int AVG_W  = 32;
	localparam int CNT_W  = 16;
	localparam int IDX_W  = 32;
	localparam int WARM_W = 4;

	localparam int IN_W  = 3 * RATE_W;
	localparam int OUT_W = AVG_W + CNT_W + IDX_W;

	// averages stay zero until this many samples have gone by
	localparam logic [WARM_W-1:0] WARM_DONE = 4'd11;
	localparam logic [AVG_W-1:0]  THR_RESET = 32'd2;

	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] mag;
	} mag_rsp_t;

	typedef struct packed {
		logic             done;
		logic [AVG_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

>>> hdl/gsd_mag.sv
`default_nettype none

module gsd_mag import gsd_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [RATE_W-1:0] rate_x,
	input  wire logic signed [RATE_W-1:0] rate_y,
	input  wire logic signed [RATE_W-1:0] rate_z,
	output mag_rsp_t                      rsp
);

	typedef enum logic [1:0] {
		P_IDLE,
		P_SQ,
		P_ROOT
	} phase_t;

	localparam logic [1:0] SQ_LAST   = 2'd2;
	localparam logic [3:0] ROOT_LAST = 4'(MAG_W - 1);

	phase_t                     phase_q;
	logic [1:0]                 sq_cnt_q;
	logic [3:0]                 k_q;
	logic signed [RATE_W-1:0]   ax_q, ay_q, az_q;
	logic [SQ_W-1:0]            n_q;
	logic [SQ_W-1:0]            root_q;
	logic                       done_q;

	logic signed [RATE_W-1:0]   op;
	logic signed [2*RATE_W-1:0] prod;
	logic [SQ_W-1:0]            bitv;
	logic [SQ_W-1:0]            trial;
	logic                       take;

	always_comb begin
		unique case (sq_cnt_q)
			2'd0:    op = ax_q;
			2'd1:    op = ay_q;
			default: op = az_q;
		endcase
	end

	assign prod  = op * op;
	// digit-by-digit root, one result bit per cycle
	assign bitv  = SQ_W'(1) << {k_q, 1'b0};
	assign trial = root_q + bitv;
	assign take  = (n_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= P_IDLE;
			sq_cnt_q <= '0;
			k_q      <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (start) begin
						ax_q     <= rate_x;
						ay_q     <= rate_y;
						az_q     <= rate_z;
						n_q      <= '0;
						sq_cnt_q <= '0;
						phase_q  <= P_SQ;
					end
				end
				P_SQ: begin
					n_q      <= n_q + SQ_W'($unsigned(prod));
					sq_cnt_q <= sq_cnt_q + 2'd1;
					if (sq_cnt_q == SQ_LAST) begin
						root_q  <= '0;
						k_q     <= ROOT_LAST;
						phase_q <= P_ROOT;
					end
				end
				P_ROOT: begin
					if (take) begin
						n_q    <= n_q - trial;
						root_q <= (root_q >> 1) + bitv;
					end else begin
						root_q <= root_q >> 1;
					end
					if (k_q == '0) begin
						done_q  <= 1'b1;
						phase_q <= P_IDLE;
					end else begin
						k_q <= k_q - 4'd1;
					end
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.mag  = root_q[MAG_W-1:0];

endmodule

`default_nettype wire

>>> hdl/gsd_div.sv
`default_nettype none

module gsd_div import gsd_pkg::*; #(
	parameter int WINDOW = 10
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                go,
	input  wire logic [AVG_W+$clog2(WINDOW)-1:0]     sum,
	output div_rsp_t                                 rsp
);

	localparam int SW   = $clog2(WINDOW);
	localparam int NW   = AVG_W + SW;
	localparam int SH   = NW + SW;
	localparam int MW   = NW + 1;
	localparam int DW   = 16;
	localparam int NCH  = (NW + DW - 1) / DW;
	localparam int PADW = NCH * DW;
	localparam int PW   = DW + MW;
	localparam int AW   = PADW + MW;
	localparam int CW   = $clog2(NCH + 1);
	localparam logic [63:0]   RECIP_FULL =
		((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [MW-1:0] RECIP    = RECIP_FULL[MW-1:0];
	localparam logic [CW-1:0] CNT_LAST = CW'(NCH);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [PADW-1:0] sum_q;
	logic [PW-1:0]   prod_q;
	logic [AW-1:0]   acc_q;

	logic [PW-1:0]   prod;

	// multiply by the rounded-up reciprocal of the window length, one 16-bit
	// digit of the sum a cycle from the top, then keep the high part
	assign prod = PW'(sum_q[PADW-1 -: DW]) * PW'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				sum_q  <= PADW'(sum);
				prod_q <= '0;
				acc_q  <= '0;
			end else if (busy_q) begin
				prod_q <= prod;
				sum_q  <= sum_q << DW;
				acc_q  <= (acc_q << DW) + AW'(prod_q);
				cnt_q  <= cnt_q + CW'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = acc_q[SH +: AVG_W];

endmodule

`default_nettype wire

>>> hdl/gyro_step_detector_top.sv
// gyro step detector
// s_axis carries one gyro sample per request: rate_x, rate_y, rate_z as
// signed 16-bit counts. m_axis returns one result per sample: the moving
// average of squared magnitude changes, the step count, the index of the
// latest step, and step_now in tuser. cfg_valid/cfg_data write the gait
// threshold (reset value 2); cfg_ready is always high and writes belong
// to idle periods.
// one sample is handled at a time; its work runs through the 16-step square
// root and the four-step reciprocal multiply by the window length. the
// window of squares sits in a single-port memory read once and written
// once.
// s_axis_tready falls on acceptance and rises when the result is loaded.
// the output register holds a result while the receiver stalls; the next
// sample is taken and worked on meanwhile and waits only at loading.
// reset clears the window (valid bits), averages and counters, and sets the threshold back to 2.
`default_nettype none

module gyro_step_detector_top import gsd_pkg::*; #(
	parameter int WINDOW = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [IN_W-1:0]   s_axis_tdata,  // rate_x, rate_y, rate_z
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [OUT_W-1:0]       m_axis_tdata,  // energy_average, step_count, last_step_sample
	output logic [0:0]             m_axis_tuser,  // step_now
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [AVG_W-1:0]  cfg_data
);

	localparam int SLOT_W = $clog2(WINDOW);
	localparam int SUM_W  = AVG_W + SLOT_W;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAG,
		ST_SQ,
		ST_WR,
		ST_DIV,
		ST_CMT
	} state_t;

	state_t            state_q;
	logic [AVG_W-1:0]  thr_q;
	logic [MAG_W-1:0]  prev_mag_q;
	logic [MAG_W-1:0]  mag_q;
	logic [SQ_W-1:0]   sq_q;
	logic [SUM_W-1:0]  sum_q;
	logic              div_go_q;
	logic [AVG_W-1:0]  avg_q;
	logic [AVG_W-1:0]  back1_q, back2_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SLOT_W-1:0] slot_q;
	logic [WARM_W-1:0] warm_q;
	logic [CNT_W-1:0]  steps_q;
	logic [IDX_W-1:0]  last_q;
	logic              m_valid_q;
	logic [OUT_W-1:0]  m_data_q;
	logic              m_user_q;

	logic [SQ_W-1:0]   win_mem [WINDOW];
	logic [WINDOW-1:0] win_vld_q;
	logic [SQ_W-1:0]   rd_s1;
	logic              rd_vld_s1;

	mag_rsp_t          mag_rsp;
	div_rsp_t          div_rsp;

	logic              in_acc;
	logic              can_cmt;
	logic              m_load;
	logic [MAG_W:0]    diff;
	logic [MAG_W-1:0]  absdiff;
	logic [SQ_W-1:0]   old_sq;
	logic [SUM_W-1:0]  sum_nxt;
	logic              step;
	logic [CNT_W-1:0]  steps_nxt;
	logic [IDX_W-1:0]  last_nxt;

	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign can_cmt       = !m_valid_q || m_axis_tready;
	assign m_load        = (state_q == ST_CMT) && can_cmt;

	gsd_mag u_mag (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.rate_x (signed'(s_axis_tdata[RATE_W-1:0])),
		.rate_y (signed'(s_axis_tdata[2*RATE_W-1:RATE_W])),
		.rate_z (signed'(s_axis_tdata[3*RATE_W-1:2*RATE_W])),
		.rsp    (mag_rsp)
	);

	gsd_div #(
		.WINDOW (WINDOW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.sum    (sum_q),
		.rsp    (div_rsp)
	);

	assign diff    = {1'b0, mag_q} - {1'b0, prev_mag_q};
	assign absdiff = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
	// unwritten slots read as zero
	assign old_sq  = rd_vld_s1 ? rd_s1 : '0;
	// running window sum: drop the old square of this slot, add the new one
	assign sum_nxt = sum_q - SUM_W'(old_sq) + SUM_W'(sq_q);

	assign step      = (avg_q >= thr_q) && (avg_q > back1_q) && (avg_q > back2_q);
	assign steps_nxt = (step && steps_q != '1) ? steps_q + CNT_W'(1) : steps_q;
	assign last_nxt  = step ? idx_q : last_q;

	// window memory
	always_ff @(posedge clk) begin
		if (state_q == ST_WR)
			win_mem[slot_q] <= sq_q;
		if (in_acc)
			rd_s1 <= win_mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			thr_q      <= THR_RESET;
			prev_mag_q <= '0;
			sum_q      <= '0;
			div_go_q   <= 1'b0;
			back1_q    <= '0;
			back2_q    <= '0;
			idx_q      <= '0;
			slot_q     <= '0;
			warm_q     <= '0;
			steps_q    <= '0;
			last_q     <= '0;
			win_vld_q  <= '0;
			rd_vld_s1  <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			if (cfg_valid)
				thr_q <= cfg_data;
			if (m_valid_q && m_axis_tready && !m_load)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						rd_vld_s1 <= win_vld_q[slot_q];
						state_q   <= ST_MAG;
					end
				end
				ST_MAG: begin
					if (mag_rsp.done) begin
						mag_q     <= mag_rsp.mag;
						state_q   <= ST_SQ;
					end
				end
				ST_SQ: begin
					state_q   <= ST_WR;
				end
				ST_WR: begin
					win_vld_q[slot_q] <= 1'b1;
					sum_q             <= sum_nxt;
					div_go_q          <= 1'b1;
					state_q           <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						avg_q   <= (warm_q == WARM_DONE) ? div_rsp.quot : '0;
						state_q <= ST_CMT;
					end
				end
				ST_CMT: begin
					if (m_load) begin
						m_valid_q  <= 1'b1;
						m_data_q   <= {last_nxt, steps_nxt, avg_q};
						m_user_q   <= step;
						steps_q    <= steps_nxt;
						last_q     <= last_nxt;
						back2_q    <= back1_q;
						back1_q    <= avg_q;
						prev_mag_q <= mag_q;
						if (warm_q != WARM_DONE)
							warm_q <= warm_q + WARM_W'(1);
						idx_q <= idx_q + IDX_W'(1);
						// slot follows the index modulo the window, also across index wrap
						if (idx_q == '1 || slot_q == SLOT_LAST)
							slot_q <= '0;
						else
							slot_q <= slot_q + SLOT_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// square of the magnitude change, registered after the multiplier
	always_ff @(posedge clk) begin
		if (state_q == ST_SQ)
			sq_q <= SQ_W'(absdiff) * SQ_W'(absdiff);
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

>>> hdl/gsd_chk.sv
`default_nettype none

module gsd_chk import gsd_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_axis_tvalid,
	input wire logic             s_axis_tready,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata,
	input wire logic [0:0]       m_axis_tuser
);

	// a stalled result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// one sample in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while a sample is in flight");

	// a step needs a non-zero average
	a_step_avg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[AVG_W-1:0] != '0)
		else $error("step flagged on a zero average");

	// a step leaves the count non-zero
	a_step_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[AVG_W+CNT_W-1:AVG_W] != '0)
		else $error("step flagged with zero step count");

endmodule

bind gyro_step_detector_top gsd_chk u_gsd_chk (.*);

`default_nettype wire

>>> verif/step_result_checker.sv
`timescale 1ns / 100ps

module step_result_checker import gsd_pkg::*; #(
	parameter int WINDOW = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [IN_W-1:0]   s_axis_tdata,  // rate_x, rate_y, rate_z
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [OUT_W-1:0]  m_axis_tdata,  // energy_average, step_count, last_step_sample
	input  logic [0:0]        m_axis_tuser,  // step_now
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [AVG_W-1:0]  cfg_data,
	output int                fail_count,
	output int                pending,
	output int                results_seen,
	output int                steps_seen
);

	typedef struct packed {
		logic [AVG_W-1:0] avg;
		logic             step;
		logic [CNT_W-1:0] count;
		logic [IDX_W-1:0] last_at;
	} step_result_t;

	step_result_t expected_steps[$];

	// predictor state
	logic [AVG_W-1:0]  threshold;
	logic [MAG_W-1:0]  prev_mag;
	logic [SQ_W-1:0]   square_ring [WINDOW];
	logic [AVG_W-1:0]  avg_d1;
	logic [AVG_W-1:0]  avg_d2;
	logic [IDX_W-1:0]  sample_no;
	logic [WARM_W-1:0] warm_cnt;
	logic [CNT_W-1:0]  step_total;
	logic [IDX_W-1:0]  last_step_at;

	initial begin
		fail_count   = 0;
		pending      = 0;
		results_seen = 0;
		steps_seen   = 0;
	end

	// truncated square root of the summed squares, one result bit at a time
	function automatic logic [MAG_W-1:0] gyro_magnitude(input logic [IN_W-1:0] sample);
		int ax, ay, az;
		longint power;
		logic [MAG_W-1:0] root, trial;
		ax = $signed(sample[RATE_W-1:0]);
		ay = $signed(sample[2*RATE_W-1:RATE_W]);
		az = $signed(sample[3*RATE_W-1:2*RATE_W]);
		power = longint'(ax * ax) + longint'(ay * ay) + longint'(az * az);
		root = '0;
		for (int b = MAG_W - 1; b >= 0; b--) begin
			trial = root;
			trial[b] = 1'b1;
			if (longint'(trial) * longint'(trial) <= power)
				root = trial;
		end
		return root;
	endfunction

	function automatic step_result_t predict_step(input logic [IN_W-1:0] sample);
		logic [MAG_W-1:0] mag;
		longint delta;
		longint unsigned sum;
		logic [AVG_W-1:0] mean;
		step_result_t r;
		mag = gyro_magnitude(sample);
		delta = longint'(mag) - longint'(prev_mag);
		if (delta < 0)
			delta = -delta;
		square_ring[sample_no % WINDOW] = SQ_W'(delta * delta);
		mean = '0;
		if (warm_cnt >= WARM_DONE) begin
			sum = 0;
			for (int i = 0; i < WINDOW; i++)
				sum += square_ring[i];
			mean = AVG_W'(sum / WINDOW);
		end
		r.step = (mean >= threshold) && (mean > avg_d1) && (mean > avg_d2);
		if (r.step) begin
			if (step_total != '1)
				step_total++;
			last_step_at = sample_no;
		end
		avg_d2 = avg_d1;
		avg_d1 = mean;
		prev_mag = mag;
		if (warm_cnt < WARM_DONE)
			warm_cnt++;
		sample_no++;
		r.avg     = mean;
		r.count   = step_total;
		r.last_at = last_step_at;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		step_result_t seen, want;
		if (!arst_n) begin
			threshold    = THR_RESET;
			prev_mag     = '0;
			avg_d1       = '0;
			avg_d2       = '0;
			sample_no    = '0;
			warm_cnt     = '0;
			step_total   = '0;
			last_step_at = '0;
			for (int i = 0; i < WINDOW; i++)
				square_ring[i] = '0;
			expected_steps.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.avg     = m_axis_tdata[AVG_W-1:0];
				seen.count   = m_axis_tdata[AVG_W+CNT_W-1:AVG_W];
				seen.last_at = m_axis_tdata[OUT_W-1:AVG_W+CNT_W];
				seen.step    = m_axis_tuser[0];
				results_seen++;
				if (expected_steps.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result %0d arrived with nothing outstanding",
							$realtime, results_seen);
				end else begin
					want = expected_steps.pop_front();
					if (want.step)
						steps_seen++;
					if (want !== seen) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"%0t: result %0d mismatch: expected avg=%0d step=%0b ",
								"count=%0d last=%0d, got avg=%0d step=%0b count=%0d last=%0d"},
								$realtime, results_seen, want.avg, want.step, want.count,
								want.last_at, seen.avg, seen.step, seen.count, seen.last_at);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_steps.push_back(predict_step(s_axis_tdata));
			if (cfg_valid && cfg_ready)
				threshold = cfg_data;
		end
		pending = expected_steps.size();
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb import gsd_pkg::*;;

	localparam int WINDOW      = 10;
	localparam int HOLD_CYCLES = 800;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 160;

	logic              clk;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata  = '0;  // rate_x, rate_y, rate_z
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;        // energy_average, step_count, last_step_sample
	logic [0:0]        m_axis_tuser;        // step_now
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [AVG_W-1:0]  cfg_data      = '0;

	int fail_count, pending, results_seen, steps_seen;
	int samples_sent = 0;
	bit tx_steady    = 1'b0;

	gyro_step_detector_top #(.WINDOW(WINDOW)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	step_result_checker #(.WINDOW(WINDOW)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.results_seen  (results_seen),
		.steps_seen    (steps_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// mostly short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 30);
		return $urandom_range(40, 200);
	endfunction

	function automatic int swing(input int lvl);
		int v;
		v = $urandom_range(lvl / 2, lvl);
		return $urandom_range(0, 1) ? v : -v;
	endfunction

	function automatic int corner_value();
		unique case ($urandom_range(0, 4))
			0: return -32768;
			1: return 32767;
			2: return -1;
			3: return 1;
			default: return 0;
		endcase
	endfunction

	task automatic push_sample(input int x, input int y, input int z);
		int gap;
		gap = tx_steady ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {z[15:0], y[15:0], x[15:0]};
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// receiver: random stalls, steady stretches, and one long hold-off
	initial begin
		int stall_left;
		bit steady, hold_used;
		stall_left = 0;
		steady     = 1'b0;
		hold_used  = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_used && results_seen >= 300) begin
				hold_used  = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 499) == 0)
					steady = !steady;
				if (!steady && $urandom_range(0, 2) == 0)
					stall_left = idle_len();
			end
		end
	end

	initial begin
		logic [AVG_W-1:0] thr_plan [PHASES];
		int pick, stride_pos, stride_len, amp, lvl, ax, ay, az;
		stride_pos = 0;
		stride_len = 1;
		amp        = 4;
		thr_plan[0] = '0;
		thr_plan[1] = '1;
		thr_plan[2] = $urandom_range(1, 5000);
		thr_plan[3] = $urandom_range(100_000, 20_000_000);
		thr_plan[4] = THR_RESET;
		thr_plan[5] = $urandom_range(32'h1000_0000, 32'h4000_0000);
		thr_plan[6] = $urandom();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, reset threshold: first sample against a zero magnitude,
		// extremes through warm-up, then rising averages
		push_sample(0, 0, 0);
		push_sample(-32768, -32768, -32768);
		push_sample(32767, 32767, 32767);
		push_sample(0, 0, 0);
		push_sample(-32768, 0, 0);
		push_sample(0, 32767, 0);
		push_sample(0, 0, -32768);
		push_sample(1, 0, 0);
		push_sample(-1, -1, -1);
		push_sample(0, 0, 0);
		push_sample(-32768, -32768, -32768);
		push_sample(0, 0, 0);
		push_sample(-32768, -32768, -32768);
		push_sample(0, 0, 0);
		// flush the window to zero, then an average of exactly the threshold
		repeat (11) push_sample(0, 0, 0);
		push_sample(5, 0, 0);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			repeat (4) @(negedge clk);
			cfg_valid <= 1'b1;
			cfg_data  <= thr_plan[ph];
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
			cfg_valid <= 1'b0;
			tx_steady = ($urandom_range(0, 2) == 0);

			// a still stretch so the average settles to zero
			ax = $urandom_range(0, 65535);
			ay = $urandom_range(0, 65535);
			az = $urandom_range(0, 65535);
			repeat (11) push_sample(ax, ay, az);

			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					// walking: a swing burst at the start of each stride
					if (stride_pos == 0) begin
						stride_len = $urandom_range(4, 14);
						amp = 1 << $urandom_range(2, 15);
						if (amp > 32767)
							amp = 32767;
					end
					lvl = (stride_pos <= stride_len / 3) ? amp : amp / 16;
					ax = swing(lvl);
					ay = swing(lvl);
					az = swing(lvl);
					stride_pos++;
					if (stride_pos >= stride_len)
						stride_pos = 0;
				end else if (pick < 80) begin
					ax = $urandom_range(0, 65535);
					ay = $urandom_range(0, 65535);
					az = $urandom_range(0, 65535);
				end else if (pick < 90) begin
					ax = corner_value();
					ay = corner_value();
					az = corner_value();
				end else begin
					ax = $urandom_range(0, 16) - 8;
					ay = $urandom_range(0, 16) - 8;
					az = $urandom_range(0, 16) - 8;
				end
				push_sample(ax, ay, az);
			end
		end

		drain();
		repeat (64) @(negedge clk);

		$display("covered %0d gyro samples over %0d threshold settings incl. zero and all-ones",
			samples_sent, PHASES + 1);
		$display("%0d results checked, %0d steps, one %0d-cycle output hold-off",
			results_seen, steps_seen, HOLD_CYCLES);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
